[hw/rtl/paged_object_pool_allocator_top_defines.svh]
// assertion macros of the allocator rtl, included by the back end
`ifndef PAGED_OBJECT_POOL_ALLOCATOR_TOP_DEFINES_SVH
`define PAGED_OBJECT_POOL_ALLOCATOR_TOP_DEFINES_SVH

// same-cycle implication, clocked on clk, off during reset
`define POA_ASSERT_IMP(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication
`define POA_ASSERT_NXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

[hw/rtl/poa_pkg.sv]
// shared types and constants of the object pool allocator
`default_nettype none
package poa_pkg;

	localparam int unsigned MAX_PAGES_DEF = 16;
	localparam int unsigned MAX_BPP_DEF   = 32;
	localparam int unsigned PTR_BYTES_DEF = 8;

	localparam int unsigned ADDR_W      = 20;
	localparam int unsigned CNT_OUT_W   = 10;
	localparam int unsigned PAGES_OUT_W = 5;
	localparam int unsigned TOTAL_W     = 32;

	localparam int unsigned OBJ_W      = 11;
	localparam int unsigned BPP_W      = 6;
	localparam int unsigned LIM_W      = 5;
	localparam int unsigned BYTE_W     = 8;
	localparam int unsigned CFG_IDX_W  = 3;
	localparam int unsigned CFG_DATA_W = 11;

	localparam logic [OBJ_W-1:0]  OBJ_RST   = OBJ_W'(16);
	localparam logic [BPP_W-1:0]  BPP_RST   = BPP_W'(4);
	localparam logic [LIM_W-1:0]  LIM_RST   = LIM_W'(2);
	localparam logic [OBJ_W-1:0]  OBJ_MIN   = OBJ_W'(8);
	localparam logic [OBJ_W-1:0]  OBJ_MAX   = OBJ_W'(1024);

	typedef enum logic [1:0] {
		ST_OK,
		ST_NO_MEMORY,
		ST_BAD_BOUNDARY,
		ST_MULTIPLE_FREE
	} status_t;

	typedef enum logic {
		FN_ALLOC,
		FN_FREE
	} func_t;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_OBJECT_SIZE,
		REG_BLOCKS_PER_PAGE,
		REG_PAGE_LIMIT,
		REG_PAD_SIZE,
		REG_HEADER_SIZE,
		REG_ALIGN_TO
	} cfg_reg_t;

	// layout settings, already saturated into range
	typedef struct packed {
		logic [OBJ_W-1:0]  object_size;
		logic [BPP_W-1:0]  bpp;
		logic [LIM_W-1:0]  limit;
		logic [BYTE_W-1:0] pad;
		logic [BYTE_W-1:0] header;
		logic [BYTE_W-1:0] align;
	} geo_cfg_t;

	typedef struct packed {
		logic              func;
		logic [ADDR_W-1:0] free_address;
	} item_t;

endpackage
`default_nettype wire

[hw/rtl/poa_ifs.sv]
// request, result and configuration channels of the allocator
`default_nettype none
interface poa_req_if import poa_pkg::*; ();
	logic              valid;
	logic              ready;
	logic              func;
	logic [ADDR_W-1:0] free_address;

	modport source (output valid, func, free_address, input ready);
	modport sink   (input valid, func, free_address, output ready);
endinterface

interface poa_rsp_if import poa_pkg::*; ();
	logic                   valid;
	logic                   ready;
	logic [1:0]             status;
	logic [ADDR_W-1:0]      block_address;
	logic [TOTAL_W-1:0]     alloc_serial;
	logic [CNT_OUT_W-1:0]   objects_in_use;
	logic [CNT_OUT_W-1:0]   free_blocks;
	logic [PAGES_OUT_W-1:0] pages_used;
	logic [CNT_OUT_W-1:0]   peak_in_use;
	logic [TOTAL_W-1:0]     total_allocs;
	logic [TOTAL_W-1:0]     total_frees;

	modport source (output valid, status, block_address, alloc_serial, objects_in_use,
		free_blocks, pages_used, peak_in_use, total_allocs, total_frees, input ready);
	modport sink   (input valid, status, block_address, alloc_serial, objects_in_use,
		free_blocks, pages_used, peak_in_use, total_allocs, total_frees, output ready);
endinterface

interface poa_cfg_if import poa_pkg::*; ();
	logic                  valid;
	logic                  ready;
	logic [CFG_IDX_W-1:0]  index;
	logic [CFG_DATA_W-1:0] data;

	modport source (output valid, index, data, input ready);
	modport sink   (input valid, index, data, output ready);
endinterface
`default_nettype wire

[hw/rtl/poa_div.sv]
// iterative restoring divider, one quotient bit per cycle
`default_nettype none
module poa_div #(
	parameter int unsigned W = 20
) (
	input  wire logic         clk,
	input  wire logic         arst_n,
	input  wire logic         start,
	input  wire logic [W-1:0] dividend,
	input  wire logic [W-1:0] divisor,
	output logic              done,
	output logic [W-1:0]      quo,
	output logic [W-1:0]      rem
);
	localparam int unsigned CW = (W > 1) ? $clog2(W) : 1;

	logic         busy_q;
	logic [CW-1:0] cnt_q;
	logic [W-1:0] quo_q;
	logic [W-1:0] rem_q;
	logic [W-1:0] dsr_q;
	logic         done_q;
	logic [W:0]   trial;
	logic         fits;

	assign trial = {rem_q, quo_q[W-1]};
	assign fits  = trial >= {1'b0, dsr_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 1'b1;
				if (cnt_q == CW'(W - 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			quo_q <= dividend;
			rem_q <= '0;
			dsr_q <= divisor;
		end else if (busy_q) begin
			rem_q <= fits ? W'(trial - {1'b0, dsr_q}) : trial[W-1:0];
			quo_q <= {quo_q[W-2:0], fits};
		end
	end

	assign done = done_q;
	assign quo  = quo_q;
	assign rem  = rem_q;
endmodule
`default_nettype wire

[hw/rtl/poa_front.sv]
// front end: configuration registers and the item queue
`default_nettype none
module poa_front import poa_pkg::*; #(
	parameter int unsigned MAX_PAGES = MAX_PAGES_DEF,
	parameter int unsigned MAX_BPP   = MAX_BPP_DEF
) (
	input  wire logic  clk,
	input  wire logic  arst_n,
	poa_req_if.sink    req,
	poa_cfg_if.sink    cfg,
	output item_t      q_item,
	output logic       q_valid,
	input  wire logic  q_pop,
	output geo_cfg_t   geo,
	output logic       reinit
);
	localparam int unsigned Q_DEPTH = 2;

	logic [OBJ_W-1:0]  obj_q;
	logic [BPP_W-1:0]  bpp_q;
	logic [LIM_W-1:0]  lim_q;
	logic [BYTE_W-1:0] pad_q;
	logic [BYTE_W-1:0] hdr_q;
	logic [BYTE_W-1:0] align_q;
	logic              reinit_q;

	item_t      ent_q [Q_DEPTH];
	logic       wp_q;
	logic       rp_q;
	logic [1:0] cnt_q;
	logic       push;

	assign cfg.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			obj_q    <= OBJ_RST;
			bpp_q    <= BPP_RST;
			lim_q    <= LIM_RST;
			pad_q    <= '0;
			hdr_q    <= '0;
			align_q  <= '0;
			reinit_q <= 1'b0;
		end else begin
			reinit_q <= 1'b0;
			if (cfg.valid) begin
				reinit_q <= 1'b1;
				case (cfg_reg_t'(cfg.index))
					REG_OBJECT_SIZE:     obj_q   <= cfg.data;
					REG_BLOCKS_PER_PAGE: bpp_q   <= cfg.data[BPP_W-1:0];
					REG_PAGE_LIMIT:      lim_q   <= cfg.data[LIM_W-1:0];
					REG_PAD_SIZE:        pad_q   <= cfg.data[BYTE_W-1:0];
					REG_HEADER_SIZE:     hdr_q   <= cfg.data[BYTE_W-1:0];
					REG_ALIGN_TO:        align_q <= cfg.data[BYTE_W-1:0];
					default:             reinit_q <= 1'b0;
				endcase
			end
		end
	end

	// saturate settings into their legal ranges
	always_comb begin
		geo.object_size = (obj_q < OBJ_MIN) ? OBJ_MIN : (obj_q > OBJ_MAX) ? OBJ_MAX : obj_q;
		geo.bpp   = (bpp_q == '0) ? BPP_W'(1) :
			(32'(bpp_q) > MAX_BPP) ? BPP_W'(MAX_BPP) : bpp_q;
		geo.limit = (lim_q == '0) ? LIM_W'(1) :
			(32'(lim_q) > MAX_PAGES) ? LIM_W'(MAX_PAGES) : lim_q;
		geo.pad    = pad_q;
		geo.header = hdr_q;
		geo.align  = align_q;
	end

	assign reinit = reinit_q;

	// two-entry queue toward the back end
	assign req.ready = cnt_q != 2'(Q_DEPTH);
	assign push      = req.valid && req.ready;
	assign q_valid   = cnt_q != '0;
	assign q_item    = ent_q[rp_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q  <= 1'b0;
			rp_q  <= 1'b0;
			cnt_q <= '0;
		end else begin
			if (push) wp_q <= ~wp_q;
			if (q_pop) rp_q <= ~rp_q;
			cnt_q <= cnt_q + 2'(push) - 2'(q_pop);
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			ent_q[wp_q].func         <= req.func;
			ent_q[wp_q].free_address <= req.free_address;
		end
	end
endmodule
`default_nettype wire

[hw/rtl/poa_back.sv]
// back end: layout setup, free list, in-use map, counters and result register
`default_nettype none
module poa_back import poa_pkg::*; #(
	parameter int unsigned MAX_PAGES = MAX_PAGES_DEF,
	parameter int unsigned MAX_BPP   = MAX_BPP_DEF,
	parameter int unsigned PTR_BYTES = PTR_BYTES_DEF
) (
	input  wire logic     clk,
	input  wire logic     arst_n,
	input  wire item_t    q_item,
	input  wire logic     q_valid,
	output logic          q_pop,
	input  wire geo_cfg_t geo,
	input  wire logic     reinit,
	poa_rsp_if.source     rsp
);
	`include "paged_object_pool_allocator_top_defines.svh"

	localparam int unsigned PG_W     = (MAX_PAGES > 1) ? $clog2(MAX_PAGES) : 1;
	localparam int unsigned J_W      = (MAX_BPP > 1) ? $clog2(MAX_BPP) : 1;
	localparam int unsigned IDX_W    = PG_W + J_W;
	localparam int unsigned USE_DEPTH = 2 ** IDX_W;
	localparam int unsigned POOL     = MAX_PAGES * MAX_BPP;
	localparam int unsigned SP_W     = (POOL > 1) ? $clog2(POOL) : 1;
	localparam int unsigned DEPTH_W  = $clog2(POOL + 1);
	localparam int unsigned PCNT_W   = $clog2(MAX_PAGES + 1);
	localparam int unsigned FL_W     = $clog2(MAX_BPP + 1);

	typedef enum logic [4:0] {
		S_G0, S_G0W, S_G1, S_G1W, S_GMUL, S_GSUM, S_CLR,
		S_IDLE, S_APOP, S_AMUL, S_ASUM,
		S_FD0, S_FD1, S_FRD, S_FCHK, S_OUT
	} state_t;

	state_t state_q;

	// layout
	logic [BYTE_W-1:0] la_q;
	logic [BYTE_W-1:0] ia_q;
	logic [ADDR_W-1:0] first_q;
	logic [ADDR_W-1:0] stride_q;
	logic [ADDR_W-1:0] page_q;
	logic [ADDR_W-1:0] m1_q;
	logic [ADDR_W-1:0] m2_q;
	logic [ADDR_W-1:0] left;
	logic [ADDR_W-1:0] inner;

	// divider
	logic              div_start_q;
	logic [ADDR_W-1:0] div_a_q;
	logic [ADDR_W-1:0] div_b_q;
	logic              div_done;
	logic [ADDR_W-1:0] div_quo;
	logic [ADDR_W-1:0] div_rem;

	// memories
	logic [IDX_W-1:0] stack_mem [POOL];
	logic [IDX_W-1:0] stack_rd_q;
	logic [SP_W-1:0]  stack_ra;
	logic             stack_we;
	logic             use_mem [USE_DEPTH];
	logic             use_rd_q;
	logic             use_we;
	logic [IDX_W-1:0] use_wa;
	logic             use_wd;

	// pool state
	logic [DEPTH_W-1:0] depth_q;
	logic [PG_W-1:0]    fresh_page_q;
	logic [FL_W-1:0]    fresh_left_q;
	logic [PCNT_W-1:0]  page_count_q;
	logic [DEPTH_W-1:0] use_q;
	logic [DEPTH_W-1:0] peak_q;
	logic [TOTAL_W-1:0] alloc_total_q;
	logic [TOTAL_W-1:0] free_total_q;
	logic [TOTAL_W-1:0] serial_q;
	logic [IDX_W-1:0]   clr_q;

	// current item
	logic [PG_W-1:0]    pg_q;
	logic [J_W-1:0]     j_q;
	status_t            status_q;
	logic [ADDR_W-1:0]  addr_q;
	logic [TOTAL_W-1:0] ser_q;

	// fresh page take
	logic               fr_take;
	logic [PG_W-1:0]    fr_page;
	logic [FL_W-1:0]    fr_left;
	logic [PCNT_W-1:0]  fr_pcnt;

	logic rsp_valid_q;

	assign left  = ADDR_W'(PTR_BYTES) + ADDR_W'(geo.pad) + ADDR_W'(geo.header);
	assign inner = ADDR_W'(geo.object_size) + (ADDR_W'(geo.pad) << 1) + ADDR_W'(geo.header);

	assign fr_take = (fresh_left_q == '0) && (32'(page_count_q) < 32'(geo.limit));
	assign fr_page = fr_take ? page_count_q[PG_W-1:0] : fresh_page_q;
	assign fr_left = fr_take ? FL_W'(geo.bpp) : fresh_left_q;
	assign fr_pcnt = fr_take ? page_count_q + 1'b1 : page_count_q;

	assign q_pop = (state_q == S_IDLE) && q_valid && !reinit;

	poa_div #(.W(ADDR_W)) u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start_q),
		.dividend (div_a_q),
		.divisor  (div_b_q),
		.done     (div_done),
		.quo      (div_quo),
		.rem      (div_rem)
	);

	always_comb begin
		use_we   = 1'b0;
		use_wa   = {pg_q, j_q};
		use_wd   = 1'b0;
		stack_we = 1'b0;
		stack_ra = SP_W'(depth_q - 1'b1);
		case (state_q)
			S_CLR: begin
				use_we = 1'b1;
				use_wa = clr_q;
			end
			S_ASUM: begin
				use_we = 1'b1;
				use_wd = 1'b1;
			end
			S_FCHK: begin
				use_we   = use_rd_q;
				stack_we = use_rd_q;
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk) begin
		if (use_we) use_mem[use_wa] <= use_wd;
		use_rd_q <= use_mem[{pg_q, j_q}];
		if (stack_we) stack_mem[depth_q[SP_W-1:0]] <= {pg_q, j_q};
		stack_rd_q <= stack_mem[stack_ra];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q       <= S_G0;
			div_start_q   <= 1'b0;
			depth_q       <= '0;
			fresh_page_q  <= '0;
			fresh_left_q  <= '0;
			page_count_q  <= PCNT_W'(1);
			use_q         <= '0;
			peak_q        <= '0;
			alloc_total_q <= '0;
			free_total_q  <= '0;
			serial_q      <= '0;
			clr_q         <= '0;
			rsp_valid_q   <= 1'b0;
		end else begin
			div_start_q <= 1'b0;
			if (rsp_valid_q && rsp.ready) rsp_valid_q <= 1'b0;
			if (reinit) begin
				state_q <= S_G0;
			end else begin
				case (state_q)
					S_G0: begin
						la_q <= '0;
						if (geo.align != '0) begin
							div_start_q <= 1'b1;
							div_a_q     <= left;
							div_b_q     <= ADDR_W'(geo.align);
							state_q     <= S_G0W;
						end else begin
							state_q <= S_G1;
						end
					end
					S_G0W: if (div_done) begin
						la_q    <= (div_rem == '0) ? '0 : geo.align - div_rem[BYTE_W-1:0];
						state_q <= S_G1;
					end
					S_G1: begin
						ia_q <= '0;
						if (geo.align != '0) begin
							div_start_q <= 1'b1;
							div_a_q     <= inner;
							div_b_q     <= ADDR_W'(geo.align);
							state_q     <= S_G1W;
						end else begin
							state_q <= S_GMUL;
						end
					end
					S_G1W: if (div_done) begin
						ia_q    <= (div_rem == '0) ? '0 : geo.align - div_rem[BYTE_W-1:0];
						state_q <= S_GMUL;
					end
					S_GMUL: begin
						m1_q    <= ADDR_W'(ADDR_W'(geo.bpp) * inner);
						m2_q    <= ADDR_W'(ADDR_W'(geo.bpp - 1'b1) * ADDR_W'(ia_q));
						state_q <= S_GSUM;
					end
					S_GSUM: begin
						page_q        <= ADDR_W'(PTR_BYTES) + m1_q + ADDR_W'(la_q) + m2_q;
						first_q       <= left + ADDR_W'(la_q);
						stride_q      <= inner + ADDR_W'(ia_q);
						depth_q       <= '0;
						fresh_page_q  <= '0;
						fresh_left_q  <= FL_W'(geo.bpp);
						page_count_q  <= PCNT_W'(1);
						use_q         <= '0;
						peak_q        <= '0;
						alloc_total_q <= '0;
						free_total_q  <= '0;
						serial_q      <= '0;
						clr_q         <= '0;
						state_q       <= S_CLR;
					end
					S_CLR: begin
						clr_q <= clr_q + 1'b1;
						if (clr_q == IDX_W'(USE_DEPTH - 1)) state_q <= S_IDLE;
					end
					S_IDLE: if (q_valid) begin
						status_q <= ST_OK;
						addr_q   <= '0;
						ser_q    <= '0;
						if (func_t'(q_item.func) == FN_FREE) begin
							div_start_q <= 1'b1;
							div_a_q     <= q_item.free_address;
							div_b_q     <= page_q;
							state_q     <= S_FD0;
						end else if (depth_q != '0) begin
							depth_q <= depth_q - 1'b1;
							state_q <= S_APOP;
						end else begin
							page_count_q <= fr_pcnt;
							fresh_page_q <= fr_page;
							if (fr_left != '0) begin
								fresh_left_q <= fr_left - 1'b1;
								pg_q         <= fr_page;
								j_q          <= J_W'(fr_left - 1'b1);
								state_q      <= S_AMUL;
							end else begin
								status_q <= ST_NO_MEMORY;
								state_q  <= S_OUT;
							end
						end
					end
					S_APOP: begin
						pg_q    <= stack_rd_q[IDX_W-1:J_W];
						j_q     <= stack_rd_q[J_W-1:0];
						state_q <= S_AMUL;
					end
					S_AMUL: begin
						m1_q    <= ADDR_W'(ADDR_W'(pg_q) * page_q);
						m2_q    <= ADDR_W'(ADDR_W'(j_q) * stride_q);
						state_q <= S_ASUM;
					end
					S_ASUM: begin
						addr_q        <= m1_q + first_q + m2_q;
						serial_q      <= serial_q + 1'b1;
						ser_q         <= serial_q + 1'b1;
						alloc_total_q <= alloc_total_q + 1'b1;
						use_q         <= use_q + 1'b1;
						if (use_q + 1'b1 > peak_q) peak_q <= use_q + 1'b1;
						state_q       <= S_OUT;
					end
					S_FD0: if (div_done) begin
						// page index and offset inside the page
						if (div_quo >= ADDR_W'(page_count_q) || div_rem == '0
							|| div_rem < first_q) begin
							status_q <= ST_BAD_BOUNDARY;
							state_q  <= S_OUT;
						end else begin
							pg_q        <= div_quo[PG_W-1:0];
							div_start_q <= 1'b1;
							div_a_q     <= div_rem - first_q;
							div_b_q     <= stride_q;
							state_q     <= S_FD1;
						end
					end
					S_FD1: if (div_done) begin
						if (div_rem != '0 || div_quo >= ADDR_W'(geo.bpp)) begin
							status_q <= ST_BAD_BOUNDARY;
							state_q  <= S_OUT;
						end else begin
							j_q     <= div_quo[J_W-1:0];
							state_q <= S_FRD;
						end
					end
					S_FRD: state_q <= S_FCHK;
					S_FCHK: begin
						if (!use_rd_q) begin
							status_q <= ST_MULTIPLE_FREE;
						end else begin
							depth_q      <= depth_q + 1'b1;
							use_q        <= use_q - 1'b1;
							free_total_q <= free_total_q + 1'b1;
						end
						state_q <= S_OUT;
					end
					S_OUT: if (!rsp_valid_q || rsp.ready) begin
						rsp_valid_q        <= 1'b1;
						rsp.status         <= status_q;
						rsp.block_address  <= addr_q;
						rsp.alloc_serial   <= ser_q;
						rsp.objects_in_use <= CNT_OUT_W'(use_q);
						rsp.free_blocks    <= CNT_OUT_W'(32'(depth_q) + 32'(fresh_left_q));
						rsp.pages_used     <= PAGES_OUT_W'(page_count_q);
						rsp.peak_in_use    <= CNT_OUT_W'(peak_q);
						rsp.total_allocs   <= alloc_total_q;
						rsp.total_frees    <= free_total_q;
						state_q            <= S_IDLE;
					end
					default: state_q <= S_G0;
				endcase
			end
		end
	end

	assign rsp.valid = rsp_valid_q;

	`POA_ASSERT_IMP(a_block_balance, state_q == S_IDLE && !reinit,
		32'(use_q) + 32'(depth_q) + 32'(fresh_left_q) == 32'(page_count_q) * 32'(geo.bpp),
		"blocks in use and free do not add up to the pages held")
	`POA_ASSERT_IMP(a_result_source, $rose(rsp_valid_q), $past(state_q) == S_OUT,
		"result raised outside the result state")
	`POA_ASSERT_IMP(a_div_owner, div_done,
		state_q == S_G0W || state_q == S_G1W || state_q == S_FD0 || state_q == S_FD1,
		"divider finished with nobody waiting")
	`POA_ASSERT_NXT(a_check_to_out, state_q == S_FCHK && !reinit, state_q == S_OUT,
		"free check did not hand over to the result")
endmodule
`default_nettype wire

[hw/rtl/paged_object_pool_allocator_top.sv]
// top level of the paged object pool allocator
//
//  channel | dir | handshake     | payload
//  req     | in  | valid / ready | func, free_address
//  rsp     | out | valid / ready | status, block_address, alloc_serial, stats
//  cfg     | in  | valid / ready | index, data (ready always high)
//
// allocate runs S_APOP (reuse only), S_AMUL and S_ASUM to the result; no_memory skips all three
// free runs two divides, by page size and by block stride; a boundary reject skips the rest
// after reset and after each config write to a known register the layout is rebuilt
// and the in-use map is cleared, one entry a cycle (512 entries at default sizes)
// a two-item queue takes requests while the back end works or the result waits
`default_nettype none
module paged_object_pool_allocator_top import poa_pkg::*; #(
	parameter int unsigned MAX_PAGES = MAX_PAGES_DEF,
	parameter int unsigned MAX_BPP   = MAX_BPP_DEF,
	parameter int unsigned PTR_BYTES = PTR_BYTES_DEF
) (
	input  wire logic clk,
	input  wire logic arst_n,
	poa_req_if.sink   req,
	poa_rsp_if.source rsp,
	poa_cfg_if.sink   cfg
);
	item_t    q_item;
	logic     q_valid;
	logic     q_pop;
	geo_cfg_t geo;
	logic     reinit;

	poa_front #(
		.MAX_PAGES (MAX_PAGES),
		.MAX_BPP   (MAX_BPP)
	) u_front (
		.clk     (clk),
		.arst_n  (arst_n),
		.req     (req),
		.cfg     (cfg),
		.q_item  (q_item),
		.q_valid (q_valid),
		.q_pop   (q_pop),
		.geo     (geo),
		.reinit  (reinit)
	);

	poa_back #(
		.MAX_PAGES (MAX_PAGES),
		.MAX_BPP   (MAX_BPP),
		.PTR_BYTES (PTR_BYTES)
	) u_back (
		.clk     (clk),
		.arst_n  (arst_n),
		.q_item  (q_item),
		.q_valid (q_valid),
		.q_pop   (q_pop),
		.geo     (geo),
		.reinit  (reinit),
		.rsp     (rsp)
	);
endmodule
`default_nettype wire
